// ----- design/cvsw_pkg.sv -----
package cvsw_pkg;

  localparam int POS_BITS_DEFAULT = 32;
  localparam int OP_W = 4;
  localparam int CNT_W = 28;
  localparam int WORD_W = 32;
  localparam int QUEUE_DEPTH = 2;

  // BAM operation codes
  localparam logic [OP_W-1:0] OP_M  = 4'd0;
  localparam logic [OP_W-1:0] OP_I  = 4'd1;
  localparam logic [OP_W-1:0] OP_D  = 4'd2;
  localparam logic [OP_W-1:0] OP_N  = 4'd3;
  localparam logic [OP_W-1:0] OP_S  = 4'd4;
  localparam logic [OP_W-1:0] OP_H  = 4'd5;
  localparam logic [OP_W-1:0] OP_P  = 4'd6;
  localparam logic [OP_W-1:0] OP_EQ = 4'd7;
  localparam logic [OP_W-1:0] OP_X  = 4'd8;

  // Operation classes
  localparam logic [2:0] CL_MATCH = 3'd0;
  localparam logic [2:0] CL_INS   = 3'd1;
  localparam logic [2:0] CL_GAP   = 3'd2;
  localparam logic [2:0] CL_CLIP  = 3'd3;
  localparam logic [2:0] CL_NONE  = 3'd4;
  localparam logic [2:0] CL_ILL   = 3'd5;

  // Walk phases
  localparam logic [1:0] PH_SEEK  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_TRAIL = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  // Emitted kinds
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_COPY = 2'd1;
  localparam logic [1:0] K_CLIP = 2'd2;
  localparam logic [1:0] K_GAP  = 2'd3;

  typedef struct packed {
    logic              first;
    logic              last;
    logic [OP_W-1:0]   op;
    logic [2:0]        cls;
    logic [CNT_W-1:0]  cnt;
    logic              start_err;
    logic [WORD_W-1:0] ref_len;
    logic [WORD_W-1:0] alt_len;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  function automatic logic [2:0] op_class(input logic [OP_W-1:0] op);
    logic [2:0] cls;
    case (op)
      OP_M, OP_EQ, OP_X: cls = CL_MATCH;
      OP_I:              cls = CL_INS;
      OP_D, OP_N:        cls = CL_GAP;
      OP_S:              cls = CL_CLIP;
      OP_H, OP_P:        cls = CL_NONE;
      default:           cls = CL_ILL;
    endcase
    return cls;
  endfunction

endpackage

// ----- design/cvsw_if.sv -----
interface cvsw_cigar_if;
  logic                         valid;
  logic                         ready;
  logic                         first_op;
  logic                         last_op;
  logic [cvsw_pkg::OP_W-1:0]    cigar_op;
  logic [cvsw_pkg::CNT_W-1:0]   op_length;
  logic [cvsw_pkg::WORD_W-1:0]  read_start;
  logic [cvsw_pkg::WORD_W-1:0]  variant_pos;
  logic [cvsw_pkg::WORD_W-1:0]  ref_length;
  logic [cvsw_pkg::WORD_W-1:0]  alt_length;

  modport source (
    output valid, first_op, last_op, cigar_op, op_length, read_start, variant_pos,
           ref_length, alt_length,
    input  ready
  );
  modport sink (
    input  valid, first_op, last_op, cigar_op, op_length, read_start, variant_pos,
           ref_length, alt_length,
    output ready
  );
endinterface

interface cvsw_slice_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   emit_kind;
  logic [cvsw_pkg::WORD_W-1:0]  query_start;
  logic [cvsw_pkg::CNT_W-1:0]   emit_length;
  logic                         read_done;
  logic                         supported;
  logic                         error;

  modport source (
    output valid, emit_kind, query_start, emit_length, read_done, supported, error,
    input  ready
  );
  modport sink (
    input  valid, emit_kind, query_start, emit_length, read_done, supported, error,
    output ready
  );
endinterface

interface cvsw_cfg_if;
  logic valid;
  logic ready;
  logic include_clipping;

  modport source (output valid, include_clipping, input ready);
  modport sink (input valid, include_clipping, output ready);
endinterface

// ----- design/cigar_variant_slice_walker.sv -----
// CIGAR variant slice walker.
//
// The cigar channel takes one CIGAR operation of an aligned read per item; an item with
// first_op set also loads the read start, the variant position and both allele lengths.
// The slice channel returns exactly one item for every operation: the query slice to copy,
// a clipped slice, a gap mark or nothing, with read_done, supported and error flags.
// The cfg channel writes include_clipping; it is always ready. The user must write it only
// while the block is idle; the block itself does not enforce this.
//
// An accepted operation is registered in a two-entry queue and then in the output register,
// which it enters once that register is empty or being taken. An operation can be accepted
// in every cycle while the queue is not full: the front decodes it into the queue, and the
// back end walks one operation per cycle while the output register is free or being taken,
// through its compare-and-subtract recurrence on the read state.
// When the receiver stalls, the result is held in the output register and the queue fills;
// cigar.ready falls only once both queue entries are taken.
// Reset (synchronous) empties the queue, drops any held result, clears include_clipping and
// returns the walk to the seek phase with all positions and lengths at zero.
module cigar_variant_slice_walker #(
  parameter int POS_BITS = cvsw_pkg::POS_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  cvsw_cigar_if.sink    cigar,
  cvsw_slice_if.source  slice,
  cvsw_cfg_if.sink      cfg
);
  import cvsw_pkg::*;

  // A queue entry holds the decoded operation and the seek distance of a first item.
  localparam int ENTRY_W = ITEM_W + POS_BITS;

  item_t               f_item;
  logic [POS_BITS-1:0] f_dist;
  logic                push;
  logic                full;
  logic                pop;
  logic                q_valid;
  logic [ENTRY_W-1:0]  q_data;
  item_t               q_item;
  logic [POS_BITS-1:0] q_dist;

  cvsw_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .cigar    (cigar),
    .full     (full),
    .push     (push),
    .item     (f_item),
    .seek_gap (f_dist)
  );

  cvsw_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    ({f_item, f_dist}),
    .full     (full),
    .pop      (pop),
    .nonempty (q_valid),
    .rdata    (q_data)
  );

  assign {q_item, q_dist} = q_data;

  // The back end owns the read state and the output register.
  cvsw_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_dist  (q_dist),
    .pop     (pop),
    .slice   (slice)
  );
endmodule

// ----- design/cvsw_front.sv -----
module cvsw_front #(
  parameter int POS_BITS = cvsw_pkg::POS_BITS_DEFAULT
) (
  cvsw_cigar_if.sink            cigar,
  input  logic                  full,
  output logic                  push,
  output cvsw_pkg::item_t       item,
  output logic [POS_BITS-1:0]   seek_gap
);
  import cvsw_pkg::*;

  logic [POS_BITS-1:0] start_pos;
  logic [POS_BITS-1:0] var_pos;

  assign cigar.ready = !full;
  assign push        = cigar.valid && !full;

  // Positions are held at POS_BITS; the seek distance is what the back end tracks.
  assign start_pos = POS_BITS'(cigar.read_start);
  assign var_pos   = POS_BITS'(cigar.variant_pos);
  assign seek_gap  = var_pos - start_pos;

  always_comb begin
    item.first     = cigar.first_op;
    item.last      = cigar.last_op;
    item.op        = cigar.cigar_op;
    item.cls       = op_class(cigar.cigar_op);
    item.cnt       = cigar.op_length;
    item.start_err = cigar.first_op && (start_pos > var_pos);
    item.ref_len   = cigar.ref_length;
    item.alt_len   = cigar.alt_length;
  end
endmodule

// ----- design/cvsw_queue.sv -----
module cvsw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cvsw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] rdata
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- design/cvsw_back.sv -----
module cvsw_back #(
  parameter int POS_BITS = cvsw_pkg::POS_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  cvsw_cfg_if.sink              cfg,
  input  logic                  q_valid,
  input  cvsw_pkg::item_t       q_item,
  input  logic [POS_BITS-1:0]   q_dist,
  output logic                  pop,
  cvsw_slice_if.source          slice
);
  import cvsw_pkg::*;

  localparam int CMP_W = (POS_BITS > CNT_W) ? POS_BITS : CNT_W;

  logic                clip_en;
  logic [1:0]          phase, phase_next;
  logic [POS_BITS-1:0] seek_gap, seek_gap_next;
  logic [POS_BITS-1:0] qcur, qcur_next;
  logic [WORD_W-1:0]   ref_left, ref_left_next;
  logic [WORD_W-1:0]   alt_left, alt_left_next;
  logic [OP_W-1:0]     fin_op, fin_op_next;
  logic                last_gap, last_gap_next;
  logic                reached, reached_next;
  logic                failed, failed_next;

  logic [1:0]          kind;
  logic [POS_BITS-1:0] st;
  logic [CNT_W-1:0]    len;
  logic                err;
  logic [CNT_W-1:0]    rc;
  logic [CNT_W-1:0]    tk;
  logic [2:0]          cls;
  logic                compat;

  assign cfg.ready = 1'b1;
  assign pop       = q_valid && (!slice.valid || slice.ready);
  assign cls       = q_item.cls;

  always_comb begin
    phase_next    = phase;
    seek_gap_next = seek_gap;
    qcur_next     = qcur;
    ref_left_next = ref_left;
    alt_left_next = alt_left;
    fin_op_next   = fin_op;
    last_gap_next = last_gap;
    reached_next  = reached;
    failed_next   = failed;
    kind          = K_NONE;
    st            = '0;
    len           = '0;
    err           = 1'b0;
    rc            = q_item.cnt;
    tk            = '0;
    compat        = 1'b0;

    if (q_item.first) begin
      phase_next    = PH_SEEK;
      seek_gap_next = q_dist;
      qcur_next     = '0;
      ref_left_next = q_item.ref_len;
      alt_left_next = q_item.alt_len;
      fin_op_next   = '0;
      last_gap_next = 1'b0;
      reached_next  = 1'b0;
      failed_next   = 1'b0;
      if (q_item.start_err) begin
        err         = 1'b1;
        failed_next = 1'b1;
        phase_next  = PH_STOP;
      end
    end

    if (cls == CL_ILL) begin
      err         = 1'b1;
      failed_next = 1'b1;
      phase_next  = PH_STOP;
    end

    // Seek: advance the cursors towards the variant; any remainder falls into the read phase.
    if (phase_next == PH_SEEK) begin
      if (seek_gap_next != '0) begin
        if (cls inside {CL_MATCH, CL_GAP}) begin
          if (CMP_W'(rc) > CMP_W'(seek_gap_next)) begin
            tk = CNT_W'(seek_gap_next);
          end else begin
            tk = rc;
          end
          rc            = rc - tk;
          seek_gap_next = seek_gap_next - POS_BITS'(tk);
          if (cls == CL_MATCH) begin
            qcur_next = qcur_next + POS_BITS'(tk);
          end
        end else if (cls inside {CL_INS, CL_CLIP}) begin
          qcur_next = qcur_next + POS_BITS'(rc);
          rc        = '0;
        end else begin
          rc = '0;
        end
        if (rc != '0) begin
          phase_next = PH_READ;
        end
      end else begin
        phase_next = PH_READ;
      end
    end

    if (phase_next == PH_READ) begin
      case (cls)
        CL_MATCH: begin
          tk = (WORD_W'(rc) < ref_left_next) ? rc : CNT_W'(ref_left_next);
          if (tk != '0) begin
            kind          = K_COPY;
            st            = qcur_next;
            len           = tk;
            last_gap_next = 1'b0;
          end
          qcur_next     = qcur_next + POS_BITS'(tk);
          ref_left_next = ref_left_next - WORD_W'(tk);
          alt_left_next = (alt_left_next > WORD_W'(tk)) ? alt_left_next - WORD_W'(tk) : '0;
          rc            = rc - tk;
          if (rc != '0 && ref_left_next == '0) begin
            alt_left_next = '0;
          end
        end
        CL_INS: begin
          if (rc != '0) begin
            kind          = K_COPY;
            st            = qcur_next;
            len           = rc;
            last_gap_next = 1'b0;
          end
          qcur_next     = qcur_next + POS_BITS'(rc);
          alt_left_next = (alt_left_next > WORD_W'(rc)) ? alt_left_next - WORD_W'(rc) : '0;
          rc            = '0;
        end
        CL_GAP: begin
          if (ref_left_next < WORD_W'(rc) && !last_gap_next) begin
            kind          = K_GAP;
            last_gap_next = 1'b1;
          end
          ref_left_next = (ref_left_next > WORD_W'(rc)) ? ref_left_next - WORD_W'(rc) : '0;
          rc            = '0;
        end
        CL_CLIP: begin
          if (clip_en && rc != '0) begin
            kind          = K_CLIP;
            st            = qcur_next;
            len           = rc;
            last_gap_next = 1'b0;
          end
          qcur_next     = qcur_next + POS_BITS'(rc);
          alt_left_next = (alt_left_next > WORD_W'(rc)) ? alt_left_next - WORD_W'(rc) : '0;
          rc            = '0;
        end
        default: begin
          rc = '0;
        end
      endcase
      if (ref_left_next == '0 && alt_left_next == '0) begin
        reached_next = 1'b1;
        fin_op_next  = q_item.op;
        phase_next   = (rc != '0) ? PH_STOP : PH_TRAIL;
      end
    end else if (phase_next == PH_TRAIL) begin
      compat = ((op_class(fin_op_next) == CL_GAP) && (cls == CL_GAP)) ||
               ((op_class(fin_op_next) == CL_NONE) && (cls == CL_NONE)) ||
               (fin_op_next == q_item.op);
      if (cls == CL_CLIP) begin
        if (clip_en && rc != '0) begin
          kind          = K_CLIP;
          st            = qcur_next;
          len           = rc;
          last_gap_next = 1'b0;
        end
        qcur_next = qcur_next + POS_BITS'(rc);
      end else if (!compat || cls == CL_MATCH) begin
        phase_next = PH_STOP;
      end else if (cls == CL_INS) begin
        if (rc != '0) begin
          kind          = K_COPY;
          st            = qcur_next;
          len           = rc;
          last_gap_next = 1'b0;
        end
        qcur_next = qcur_next + POS_BITS'(rc);
      end else if (cls == CL_GAP) begin
        if (!last_gap_next) begin
          kind          = K_GAP;
          last_gap_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_en     <= 1'b0;
      phase       <= PH_SEEK;
      seek_gap    <= '0;
      qcur        <= '0;
      ref_left    <= '0;
      alt_left    <= '0;
      fin_op      <= '0;
      last_gap    <= 1'b0;
      reached     <= 1'b0;
      failed      <= 1'b0;
      slice.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        clip_en <= cfg.include_clipping;
      end
      if (pop) begin
        phase    <= phase_next;
        seek_gap <= seek_gap_next;
        qcur     <= qcur_next;
        ref_left <= ref_left_next;
        alt_left <= alt_left_next;
        fin_op   <= fin_op_next;
        last_gap <= last_gap_next;
        reached  <= reached_next;
        failed   <= failed_next;
        slice.valid <= 1'b1;
      end else if (slice.ready) begin
        slice.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slice.emit_kind   <= kind;
      slice.query_start <= WORD_W'(st);
      slice.emit_length <= len;
      slice.read_done   <= q_item.last;
      slice.supported   <= q_item.last && reached_next && !failed_next;
      slice.error       <= err;
    end
  end
endmodule

// ----- dv/cvsw_walk_checker.sv -----
`timescale 1ns / 1ps

module cvsw_walk_checker (
  input  logic  clk,
  input  logic  rst,
  cvsw_cigar_if cigar,
  cvsw_slice_if slice,
  cvsw_cfg_if   cfg,
  output int    failures,
  output int    outstanding
);
  import cvsw_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic              starts_read;
    logic              is_last;
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  len;
    logic [WORD_W-1:0] read_pos;
    logic [WORD_W-1:0] var_pos;
    logic [WORD_W-1:0] ref_len;
    logic [WORD_W-1:0] alt_len;
  } cigar_op_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] qstart;
    logic [CNT_W-1:0]  len;
    logic              done;
    logic              supp;
    logic              err;
  } slice_result_t;

  // Walker state, kept at the block's position width.
  logic [1:0]        walk_phase;
  logic [WORD_W-1:0] ref_pos, query_pos, variant_at, ref_rem, alt_rem;
  logic [OP_W-1:0]   finish_op;
  logic              gap_last, reached, failed;
  logic              clip_on;
  slice_result_t     scratch;

  slice_result_t expected_slices[$];

  function automatic logic [WORD_W-1:0] min_pos(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic is_match(input logic [OP_W-1:0] op);
    return op == OP_M || op == OP_EQ || op == OP_X;
  endfunction

  function automatic logic is_ref_gap(input logic [OP_W-1:0] op);
    return op == OP_D || op == OP_N;
  endfunction

  function automatic logic is_void_op(input logic [OP_W-1:0] op);
    return op == OP_H || op == OP_P;
  endfunction

  function automatic logic ops_compatible(input logic [OP_W-1:0] prev,
                                          input logic [OP_W-1:0] op);
    if (is_ref_gap(prev)) return is_ref_gap(op);
    if (is_void_op(prev)) return is_void_op(op);
    return prev == op;
  endfunction

  // A zero-length slice leaves the result empty.
  function automatic void put_slice(input logic [1:0] kind, input logic [WORD_W-1:0] len);
    if (len != '0) begin
      scratch.kind = kind;
      scratch.qstart = query_pos;
      scratch.len = len[CNT_W-1:0];
      gap_last = 1'b0;
    end
  endfunction

  // Back-to-back gap marks collapse into one.
  function automatic void put_gap();
    if (!gap_last) begin
      scratch.kind = K_GAP;
      gap_last = 1'b1;
    end
  endfunction

  function automatic void walk_variant(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] cnt_in);
    logic [WORD_W-1:0] cnt, take;
    cnt = cnt_in;
    case (op)
      OP_M, OP_EQ, OP_X: begin
        take = min_pos(cnt, ref_rem);
        put_slice(K_COPY, take);
        query_pos += take;
        ref_rem -= take;
        alt_rem -= min_pos(alt_rem, take);
        cnt -= take;
        if (cnt != '0 && ref_rem == '0) alt_rem = '0;
      end
      OP_I: begin
        put_slice(K_COPY, cnt);
        query_pos += cnt;
        alt_rem -= min_pos(alt_rem, cnt);
        cnt = '0;
      end
      OP_D, OP_N: begin
        if (ref_rem < cnt) put_gap();
        ref_rem -= min_pos(ref_rem, cnt);
        cnt = '0;
      end
      OP_S: begin
        if (clip_on) put_slice(K_CLIP, cnt);
        query_pos += cnt;
        alt_rem -= min_pos(alt_rem, cnt);
        cnt = '0;
      end
      default: cnt = '0;
    endcase
    if (ref_rem == '0 && alt_rem == '0) begin
      reached = 1'b1;
      finish_op = op;
      walk_phase = (cnt != '0) ? PH_STOP : PH_TRAIL;
    end
  endfunction

  function automatic void walk_trail(input logic [OP_W-1:0] op,
                                     input logic [WORD_W-1:0] cnt);
    if (op == OP_S) begin
      if (clip_on) put_slice(K_CLIP, cnt);
      query_pos += cnt;
    end else if (!ops_compatible(finish_op, op) || is_match(op)) begin
      walk_phase = PH_STOP;
    end else if (op == OP_I) begin
      put_slice(K_COPY, cnt);
      query_pos += cnt;
    end else if (is_ref_gap(op)) begin
      put_gap();
    end
  endfunction

  function automatic slice_result_t predict_slice(input cigar_op_t it);
    logic [WORD_W-1:0] cnt, take;
    logic              err;
    scratch = '0;
    cnt = {{(WORD_W-CNT_W){1'b0}}, it.len};
    err = 1'b0;
    if (it.starts_read) begin
      ref_pos = it.read_pos;
      variant_at = it.var_pos;
      ref_rem = it.ref_len;
      alt_rem = it.alt_len;
      query_pos = '0;
      walk_phase = PH_SEEK;
      finish_op = OP_M;
      gap_last = 1'b0;
      reached = 1'b0;
      failed = 1'b0;
      if (ref_pos > variant_at) begin
        err = 1'b1;
        failed = 1'b1;
        walk_phase = PH_STOP;
      end
    end
    if (it.op > OP_X) begin
      err = 1'b1;
      failed = 1'b1;
      walk_phase = PH_STOP;
    end
    case (walk_phase)
      PH_SEEK: begin
        if (ref_pos < variant_at) begin
          case (it.op)
            OP_M, OP_EQ, OP_X: begin
              take = min_pos(variant_at - ref_pos, cnt);
              cnt -= take;
              ref_pos += take;
              query_pos += take;
            end
            OP_D, OP_N: begin
              take = min_pos(variant_at - ref_pos, cnt);
              cnt -= take;
              ref_pos += take;
            end
            OP_I, OP_S: begin
              query_pos += cnt;
              cnt = '0;
            end
            default: cnt = '0;
          endcase
          if (cnt != '0) begin
            walk_phase = PH_READ;
            walk_variant(it.op, cnt);
          end
        end else begin
          walk_phase = PH_READ;
          walk_variant(it.op, cnt);
        end
      end
      PH_READ:  walk_variant(it.op, cnt);
      PH_TRAIL: walk_trail(it.op, cnt);
      default: ;
    endcase
    scratch.done = it.is_last;
    scratch.supp = it.is_last && reached && !failed;
    scratch.err = err;
    return scratch;
  endfunction

  task automatic note_failure(input string what);
    failures++;
    if (failures <= PRINT_CAP) $display("[%0t] slice check: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want) note_failure($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    slice_result_t want;
    cigar_op_t     taken;
    if (rst) begin
      walk_phase = PH_SEEK;
      ref_pos = '0;
      query_pos = '0;
      variant_at = '0;
      ref_rem = '0;
      alt_rem = '0;
      finish_op = OP_M;
      gap_last = 1'b0;
      reached = 1'b0;
      failed = 1'b0;
      clip_on = 1'b0;
      expected_slices.delete();
      failures = 0;
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) clip_on = cfg.include_clipping;
      // Results pass the queue and output register first, so compare before predicting.
      if (slice.valid && slice.ready) begin
        if (expected_slices.size() == 0) begin
          note_failure("result arrived with no item waiting");
        end else begin
          want = expected_slices.pop_front();
          check_field("emit_kind", 32'(slice.emit_kind), 32'(want.kind));
          check_field("query_start", slice.query_start, want.qstart);
          check_field("emit_length", 32'(slice.emit_length), 32'(want.len));
          check_field("read_done", 32'(slice.read_done), 32'(want.done));
          check_field("supported", 32'(slice.supported), 32'(want.supp));
          check_field("error", 32'(slice.error), 32'(want.err));
        end
      end
      if (cigar.valid && cigar.ready) begin
        taken.starts_read = cigar.first_op;
        taken.is_last = cigar.last_op;
        taken.op = cigar.cigar_op;
        taken.len = cigar.op_length;
        taken.read_pos = cigar.read_start;
        taken.var_pos = cigar.variant_pos;
        taken.ref_len = cigar.ref_length;
        taken.alt_len = cigar.alt_length;
        expected_slices.insert(expected_slices.size(), predict_slice(taken));
      end
      outstanding <= expected_slices.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import cvsw_pkg::*;

  // Any code above the last BAM operation is rejected by the walker.
  localparam logic [OP_W-1:0] BAD_OP_CODE = 4'd15;
  // Each random phase stops once this many further operations have gone in.
  localparam int PHASE_OPS = 355;
  // Edges waited out after the last predicted result has come back when draining.
  localparam int DRAIN_CYCLES = 4;
  // Far above the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  int   failures;
  int   outstanding;
  int   cycle_count = 0;
  int   ops_sent = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  cvsw_cigar_if cigar_ch ();
  cvsw_slice_if slice_ch ();
  cvsw_cfg_if   cfg_ch ();

  cigar_variant_slice_walker u_dut (
    .clk   (clk),
    .rst   (rst),
    .cigar (cigar_ch),
    .slice (slice_ch),
    .cfg   (cfg_ch)
  );

  // The checker sits beside the block, watching all three channels, and owns the prediction.
  cvsw_walk_checker u_walk_checker (
    .clk         (clk),
    .rst         (rst),
    .cigar       (cigar_ch),
    .slice       (slice_ch),
    .cfg         (cfg_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The receiver holds ready low on a random share of cycles, as the current phase asks.
  always @(posedge clk) begin
    slice_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Presents one operation, after a random number of idle cycles, and holds it until the
  // walker takes it. The ready sampled just after the edge is the value the edge saw.
  task automatic send_op(input logic starts_read, input logic is_last,
                         input logic [OP_W-1:0] op, input logic [CNT_W-1:0] len,
                         input logic [WORD_W-1:0] read_pos, input logic [WORD_W-1:0] var_pos,
                         input logic [WORD_W-1:0] ref_len, input logic [WORD_W-1:0] alt_len);
    while ($urandom_range(99) < send_idle_pct) begin
      cigar_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cigar_ch.valid <= 1'b1;
    cigar_ch.first_op <= starts_read;
    cigar_ch.last_op <= is_last;
    cigar_ch.cigar_op <= op;
    cigar_ch.op_length <= len;
    cigar_ch.read_start <= read_pos;
    cigar_ch.variant_pos <= var_pos;
    cigar_ch.ref_length <= ref_len;
    cigar_ch.alt_length <= alt_len;
    @(posedge clk);
    while (!cigar_ch.ready) @(posedge clk);
    ops_sent++;
  endtask

  // A follow-on operation: the start fields are ignored, so they carry random bits.
  task automatic send_next(input logic is_last, input logic [OP_W-1:0] op,
                           input logic [CNT_W-1:0] len);
    send_op(1'b0, is_last, op, len, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic write_clipping(input logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.include_clipping <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Lowers valid and waits until every predicted result has come back, then lets the
  // pipeline settle. The first edge makes sure the last item is already counted.
  task automatic drain_walker();
    cigar_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Weighted towards match, insertion and deletion so that reads reach the variant and
  // run into the trailing phase; a small share of illegal codes stops reads early.
  function automatic logic [OP_W-1:0] random_cigar_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return OP_M;
    if (pick < 38) return OP_EQ;
    if (pick < 44) return OP_X;
    if (pick < 56) return OP_I;
    if (pick < 68) return OP_D;
    if (pick < 74) return OP_N;
    if (pick < 84) return OP_S;
    if (pick < 90) return OP_H;
    if (pick < 98) return OP_P;
    return 4'($urandom_range(9, 15));
  endfunction

  // Mostly short runs; now and then a full-width count so every bit of the length moves.
  function automatic logic [CNT_W-1:0] random_length();
    if ($urandom_range(99) < 4) return CNT_W'($urandom);
    return CNT_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [WORD_W-1:0] random_allele_length();
    if ($urandom_range(99) < 5) return $urandom;
    return $urandom_range(0, 6);
  endfunction

  // One well-formed read: the variant lies a short way past the read start, so the walk
  // gets through seeking into the slice and trailing phases. A few reads start after the
  // variant, a few miss their closing flag.
  task automatic send_random_read();
    logic [WORD_W-1:0] read_pos, var_pos, ref_len, alt_len;
    logic [OP_W-1:0]   op;
    logic              drop_last;
    int                n_ops, pick;
    read_pos = $urandom;
    pick = $urandom_range(99);
    if (pick < 88) var_pos = read_pos + $urandom_range(0, 12);
    else if (pick < 94) var_pos = read_pos - $urandom_range(1, 4);
    else var_pos = $urandom;
    ref_len = random_allele_length();
    alt_len = random_allele_length();
    n_ops = $urandom_range(1, 8);
    drop_last = ($urandom_range(99) < 5);
    for (int i = 0; i < n_ops; i++) begin
      op = (i == 0 && $urandom_range(3) == 0) ? OP_S : random_cigar_op();
      if (i == 0) begin
        send_op(1'b1, n_ops == 1 && !drop_last, op, random_length(),
                read_pos, var_pos, ref_len, alt_len);
      end else begin
        send_next(i == n_ops - 1 && !drop_last, op, random_length());
      end
    end
  endtask

  // Loose operations with random flags and any code, including stray first and last marks.
  task automatic send_noise();
    int n_ops;
    n_ops = $urandom_range(1, 4);
    for (int i = 0; i < n_ops; i++) begin
      send_op(1'($urandom_range(1)), 1'($urandom_range(1)), 4'($urandom_range(15)),
              random_length(), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin : stimulus
    int goal;
    rst <= 1'b1;
    cigar_ch.valid <= 1'b0;
    cigar_ch.first_op <= 1'b0;
    cigar_ch.last_op <= 1'b0;
    cigar_ch.cigar_op <= OP_M;
    cigar_ch.op_length <= '0;
    cigar_ch.read_start <= '0;
    cigar_ch.variant_pos <= '0;
    cigar_ch.ref_length <= '0;
    cigar_ch.alt_length <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.include_clipping <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reads, with clipped slices switched on and light idling on both sides.
    write_clipping(1'b1);
    send_idle_pct = 20;
    stall_pct = 20;

    // An operation before any read has started works from the reset state.
    send_next(1'b1, OP_M, 5);

    // Soft clip while seeking, a match that crosses the variant, an insertion that
    // finishes it, then a zero-length insertion, a trailing clip, a hard clip that stops
    // the walk and a match on the stopped read.
    send_op(1'b1, 1'b0, OP_S, 2, 32'd10, 32'd12, 32'd1, 32'd3);
    send_next(1'b0, OP_M, 3);
    send_next(1'b0, OP_I, 2);
    send_next(1'b0, OP_I, 0);
    send_next(1'b0, OP_S, 4);
    send_next(1'b0, OP_H, 1);
    send_next(1'b1, OP_M, 2);

    // Deletion of the reference allele: the gap mark is not repeated for the skipped
    // region that follows, and an empty clip closes the read.
    send_op(1'b1, 1'b0, OP_D, 1, 32'd0, 32'd0, 32'd3, 32'd0);
    send_next(1'b0, OP_D, 5);
    send_next(1'b0, OP_N, 3);
    send_next(1'b1, OP_S, 0);

    // A read that starts after the variant.
    send_op(1'b1, 1'b1, OP_M, 1, 32'd50, 32'd49, 32'd1, 32'd1);

    // An illegal code on the first operation, then an item on the stopped read.
    send_op(1'b1, 1'b0, BAD_OP_CODE, 0, 32'd5, 32'd5, 32'd1, 32'd1);
    send_next(1'b1, OP_M, 1);

    // Full-width counts and positions.
    send_op(1'b1, 1'b0, OP_X, '1, '0, '1, '1, '1);
    send_next(1'b0, OP_P, 0);
    send_next(1'b1, OP_EQ, '1);

    // A match straight after the variant has been finished by a match.
    send_op(1'b1, 1'b0, OP_M, 2, 32'd7, 32'd7, 32'd2, 32'd2);
    send_next(1'b1, OP_EQ, 1);

    // Random phases: no idling, a slow sender, a slow receiver, then both. Clipping
    // alternates so that soft clips are seen both skipped and emitted.
    for (int p = 0; p < 4; p++) begin
      drain_walker();
      write_clipping(p[0]);
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      goal = ops_sent + PHASE_OPS;
      while (ops_sent < goal) begin
        if ($urandom_range(99) < 8) send_noise();
        else send_random_read();
      end
    end

    drain_walker();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cvsw_pkg.sv
design/cvsw_if.sv
design/cvsw_front.sv
design/cvsw_queue.sv
design/cvsw_back.sv
design/cigar_variant_slice_walker.sv
dv/cvsw_walk_checker.sv
dv/testbench.sv
